/* rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg
// shared types, constants and field widths for the detection track table
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int MAX_TRACKS_DEF  = 16;
    localparam int MAX_PENDING_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 8;
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int IN_COORD_W = COORD_BITS_DEF;

    localparam logic [CNT_W-1:0] SAT_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_X_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DET_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AFTERGLOW  = 3'd4;

    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    localparam logic [KIND_W-1:0] EV_CONFIRMED = 3'd0;
    localparam logic [KIND_W-1:0] EV_LEFT      = 3'd1;
    localparam logic [KIND_W-1:0] EV_ADDED     = 3'd2;
    localparam logic [KIND_W-1:0] EV_DROPPED   = 3'd3;
    localparam logic [KIND_W-1:0] EV_FRAME     = 3'd4;

    typedef struct packed {
        logic                  opcode;
        logic [IN_COORD_W-1:0] box_x;
        logic [IN_COORD_W-1:0] box_y;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] x_window;
        logic [CFG_W-1:0] y_window;
        logic [CNT_W-1:0] detect_threshold;
        logic [CNT_W-1:0] miss_threshold;
        logic [CNT_W-1:0] afterglow;
    } t_cfg;

endpackage

/* rtl/dtt_ram.sv */
// ----------------------------------------------------------------------------
// dtt_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module dtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/dtt_front.sv */
// ----------------------------------------------------------------------------
// dtt_front
// input stage: two-entry word queue that decouples the port from the engine
// ----------------------------------------------------------------------------
module dtt_front
    import dtt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_data,
    output logic     o_full,
    output logic     o_valid,
    output t_in_word o_data,
    input  logic     i_take
);
    t_in_word   r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign w_push  = i_push && (r_cnt != 2'd2);
    assign w_pop   = i_take && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

/* rtl/dtt_engine.sv */
// ----------------------------------------------------------------------------
// dtt_engine
// table engine: scans, updates and compacts the track table, emits events
// ----------------------------------------------------------------------------
module dtt_engine
    import dtt_pkg::*;
#(
    parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_word  i_data,
    output logic      o_take,
    output logic      o_ev_valid,
    output t_out_word o_ev,
    input  logic      i_ev_full
);
    localparam int COORD_BITS = IN_COORD_W;
    localparam int TA_W = (MAX_TRACKS  > 1) ? $clog2(MAX_TRACKS)  : 1;
    localparam int PA_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int TC_W = $clog2(MAX_TRACKS + 1);
    localparam int PC_W = $clog2(MAX_PENDING + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [CNT_W-1:0]      det;
        logic [CNT_W-1:0]      miss;
        logic                  seen;
        logic                  just_left;
    } t_entry;
    localparam int ENT_W = $bits(t_entry);
    localparam int BOX_W = 2 * COORD_BITS;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DREAD = 9'b000000010,
        ST_DCHK  = 9'b000000100,
        ST_DEND  = 9'b000001000,
        ST_EREAD = 9'b000010000,
        ST_ECHK  = 9'b000100000,
        ST_PREAD = 9'b001000000,
        ST_PCHK  = 9'b010000000,
        ST_FRAME = 9'b100000000
    } t_state;

    t_state r_state;
    logic [TC_W-1:0] r_tcnt, r_i, r_w;
    logic [PC_W-1:0] r_pcnt, r_p;
    logic [COORD_BITS-1:0] r_bx, r_by;

    // table and pending list rams
    logic            w_t_we;
    logic [TA_W-1:0] w_t_waddr, w_t_raddr;
    t_entry          w_t_wdata, w_t_rdata;
    logic            w_p_we;
    logic [PA_W-1:0] w_p_waddr, w_p_raddr;
    logic [BOX_W-1:0] w_p_wdata, w_p_rdata;

    dtt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TRACKS)) u_tab (
        .i_clk(i_clk), .i_we(w_t_we), .i_waddr(w_t_waddr), .i_wdata(w_t_wdata),
        .i_raddr(w_t_raddr), .o_rdata(w_t_rdata)
    );
    dtt_ram #(.WIDTH(BOX_W), .DEPTH(MAX_PENDING)) u_pend (
        .i_clk(i_clk), .i_we(w_p_we), .i_waddr(w_p_waddr), .i_wdata(w_p_wdata),
        .i_raddr(w_p_raddr), .o_rdata(w_p_rdata)
    );

    // match logic
    logic [COORD_BITS-1:0] w_dx, w_dy;
    logic                  w_hit;
    t_entry                w_upd, w_pen;
    logic                  w_confirm;
    logic [CNT_W:0]        w_upper;
    logic [CNT_W-1:0]      w_m;

    always_comb begin
        w_dx  = (w_t_rdata.x > r_bx) ? w_t_rdata.x - r_bx : r_bx - w_t_rdata.x;
        w_dy  = (w_t_rdata.y > r_by) ? w_t_rdata.y - r_by : r_by - w_t_rdata.y;
        w_hit = ({{CFG_W{1'b0}}, w_dx} < {{COORD_BITS{1'b0}}, i_cfg.x_window}) &&
                ({{CFG_W{1'b0}}, w_dy} < {{COORD_BITS{1'b0}}, i_cfg.y_window});
        w_upd      = w_t_rdata;
        if (w_t_rdata.det != SAT_MAX) begin
            w_upd.det = w_t_rdata.det + 1'b1;
        end
        w_upd.seen = 1'b1;
        w_upd.x    = r_bx;
        w_upd.y    = r_by;
        w_confirm  = (w_upd.det == i_cfg.detect_threshold);
        if (w_confirm) begin
            w_upd.miss = '0;
        end

        // end of frame penalty
        w_pen   = w_t_rdata;
        w_m     = w_t_rdata.miss;
        if (!w_t_rdata.seen && w_m != SAT_MAX) begin
            w_m = w_m + 1'b1;
        end
        w_pen.miss = w_m;
        w_upper = {1'b0, i_cfg.miss_threshold} + {1'b0, i_cfg.afterglow};
        if (w_m == i_cfg.miss_threshold) begin
            w_pen.det       = '0;
            w_pen.just_left = 1'b1;
        end
        if (w_m > i_cfg.miss_threshold && {1'b0, w_m} < w_upper) begin
            w_pen.det       = '0;
            w_pen.just_left = 1'b0;
        end
        w_pen.seen = 1'b0;
    end

    t_entry w_new;
    always_comb begin
        w_new.x         = w_p_rdata[BOX_W-1 -: COORD_BITS];
        w_new.y         = w_p_rdata[COORD_BITS-1:0];
        w_new.det       = 8'd1;
        w_new.miss      = '0;
        w_new.seen      = 1'b0;
        w_new.just_left = 1'b0;
    end

    logic w_keep;
    assign w_keep = (w_pen.miss != i_cfg.afterglow);

    always_comb begin
        w_t_we    = 1'b0;
        w_t_waddr = r_i[TA_W-1:0];
        w_t_wdata = w_upd;
        w_t_raddr = r_i[TA_W-1:0];
        w_p_we    = 1'b0;
        w_p_waddr = r_pcnt[PA_W-1:0];
        w_p_wdata = {r_bx, r_by};
        w_p_raddr = r_p[PA_W-1:0];
        o_take    = (r_state == ST_IDLE);
        o_ev_valid = 1'b0;
        o_ev       = '0;
        case (r_state)
            ST_DCHK: begin
                if (w_hit) begin
                    // write once, on the cycle the state moves on
                    w_t_we = !w_confirm || !i_ev_full;
                    o_ev_valid = w_confirm;
                    o_ev = '{event_kind: EV_CONFIRMED, slot: SLOT_W'(r_i), last: 1'b1};
                end
            end
            ST_DEND: begin
                if (r_pcnt < PC_W'(MAX_PENDING)) begin
                    w_p_we = 1'b1;
                end else begin
                    o_ev_valid = 1'b1;
                    o_ev = '{event_kind: EV_DROPPED, slot: '0, last: 1'b1};
                end
            end
            ST_ECHK: begin
                w_t_waddr  = r_w[TA_W-1:0];
                w_t_wdata  = w_pen;
                w_t_we     = w_keep && (!w_pen.just_left || !i_ev_full);
                o_ev_valid = w_pen.just_left;
                o_ev = '{event_kind: EV_LEFT, slot: SLOT_W'(r_w), last: 1'b0};
            end
            ST_PCHK: begin
                w_t_waddr  = r_tcnt[TA_W-1:0];
                w_t_wdata  = w_new;
                o_ev_valid = 1'b1;
                if (r_tcnt < TC_W'(MAX_TRACKS)) begin
                    w_t_we = !i_ev_full;
                    o_ev = '{event_kind: EV_ADDED, slot: SLOT_W'(r_tcnt), last: 1'b0};
                end else begin
                    o_ev = '{event_kind: EV_DROPPED, slot: '0, last: 1'b0};
                end
            end
            ST_FRAME: begin
                o_ev_valid = 1'b1;
                o_ev = '{event_kind: EV_FRAME, slot: '0, last: 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_bx <= i_data.box_x[COORD_BITS-1:0];
            r_by <= i_data.box_y[COORD_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tcnt  <= '0;
            r_pcnt  <= '0;
            r_i     <= '0;
            r_w     <= '0;
            r_p     <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_i <= '0;
                    r_w <= '0;
                    r_p <= '0;
                    if (i_valid) begin
                        if (i_data.opcode == OP_DETECT) begin
                            r_state <= (r_tcnt == '0) ? ST_DEND : ST_DREAD;
                        end else begin
                            r_state <= (r_tcnt == '0) ? ST_PREAD : ST_EREAD;
                        end
                    end
                end
                ST_DREAD: r_state <= ST_DCHK;
                ST_DCHK: begin
                    if (w_hit) begin
                        if (!w_confirm || !i_ev_full) begin
                            r_state <= ST_IDLE;
                        end
                    end else if (r_i + 1'b1 == r_tcnt) begin
                        r_state <= ST_DEND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_DREAD;
                    end
                end
                ST_DEND: begin
                    if (r_pcnt < PC_W'(MAX_PENDING)) begin
                        r_pcnt  <= r_pcnt + 1'b1;
                        r_state <= ST_IDLE;
                    end else if (!i_ev_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EREAD: r_state <= ST_ECHK;
                ST_ECHK: begin
                    if (!w_pen.just_left || !i_ev_full) begin
                        if (w_keep) begin
                            r_w <= r_w + 1'b1;
                        end
                        if (r_i + 1'b1 == r_tcnt) begin
                            r_tcnt  <= w_keep ? r_w + 1'b1 : r_w;
                            r_state <= (r_pcnt == '0) ? ST_FRAME : ST_PREAD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_EREAD;
                        end
                    end
                end
                ST_PREAD: begin
                    r_state <= (r_pcnt == '0) ? ST_FRAME : ST_PCHK;
                end
                ST_PCHK: begin
                    if (!i_ev_full) begin
                        if (r_tcnt < TC_W'(MAX_TRACKS)) begin
                            r_tcnt <= r_tcnt + 1'b1;
                        end
                        if (r_p + 1'b1 == r_pcnt) begin
                            r_state <= ST_FRAME;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= ST_PREAD;
                        end
                    end
                end
                ST_FRAME: begin
                    if (!i_ev_full) begin
                        r_pcnt  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_tcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TC_W'(MAX_TRACKS)) else $error("track count overflow");
    a_pcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PC_W'(MAX_PENDING)) else $error("pending count overflow");
    a_ev_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && i_ev_full && r_state == ST_FRAME) |=> r_state == ST_FRAME)
        else $error("frame word lost on stall");
    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAME && !i_ev_full) |=> r_pcnt == '0)
        else $error("pending list not cleared");
`endif
endmodule

/* rtl/dtt_out_fifo.sv */
// ----------------------------------------------------------------------------
// dtt_out_fifo
// result word queue between the engine and the output port
// ----------------------------------------------------------------------------
module dtt_out_fifo
    import dtt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_data,
    output logic      o_full,
    output logic      o_empty,
    output t_out_word o_data,
    input  logic      i_pop
);
    t_out_word  r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign w_push  = i_push && (r_cnt != 2'd2);
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

/* rtl/detection_track_table.sv */
// a detection reads and checks table entries in order until one matches, else queues the box
// end of frame ages and compacts every entry, then adds each pending word, then emits a frame word
// throughput: one word at a time, set by the table scan through the single table read port
// reset: synchronous active-low; clears counts and queue pointers, sets config registers to defaults
// table and pending memories hold no reset value and need no clearing pass
// ----------------------------------------------------------------------------
// detection_track_table
// ordered compacting table of tracked objects with frame events
// ----------------------------------------------------------------------------
module detection_track_table
    import dtt_pkg::*;
#(
    parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_in_word             i_in,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output t_out_word            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    t_cfg      r_cfg;
    logic      w_valid, w_take, w_ev_valid, w_ev_full;
    t_in_word  w_word;
    t_out_word w_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{x_window: 12'd10, y_window: 12'd10, detect_threshold: 8'd5,
                       miss_threshold: 8'd5, afterglow: 8'd10};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_WINDOW:    r_cfg.x_window <= i_cfg_data;
                REG_Y_WINDOW:    r_cfg.y_window <= i_cfg_data;
                REG_DET_THRESH:  r_cfg.detect_threshold <= i_cfg_data[CNT_W-1:0];
                REG_MISS_THRESH: r_cfg.miss_threshold <= i_cfg_data[CNT_W-1:0];
                REG_AFTERGLOW:   r_cfg.afterglow <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    dtt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(i_in),
        .o_full(o_full), .o_valid(w_valid), .o_data(w_word), .i_take(w_take)
    );

    dtt_engine #(
        .MAX_TRACKS(MAX_TRACKS), .MAX_PENDING(MAX_PENDING)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(w_valid),
        .i_data(w_word), .o_take(w_take), .o_ev_valid(w_ev_valid), .o_ev(w_ev),
        .i_ev_full(w_ev_full)
    );

    dtt_out_fifo u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_ev_valid), .i_data(w_ev),
        .o_full(w_ev_full), .o_empty(o_empty), .o_data(o_out), .i_pop(i_pop)
    );
endmodule

/* sim/tb_detection_track_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_track_table
// drives detection and end-of-frame words into the track table, predicts the
// event words from a behavioural table model and checks them in order
// ----------------------------------------------------------------------------
module tb_detection_track_table;
    import dtt_pkg::*;

    localparam int NT = 16;
    localparam int NP = 16;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  det;
        logic [7:0]  miss;
        bit          seen;
        bit          gone;
    } t_track;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    t_in_word    i_in = '0;
    logic        o_full;
    logic        o_empty;
    logic        i_pop = 1'b0;
    t_out_word   o_out;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    detection_track_table dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    t_track     tracks [NT];
    int         n_tracks;
    logic [23:0] held [NP];
    int         n_held;
    logic [11:0] xw, yw;
    logic [7:0]  dth, mth, ag;

    t_in_word  pending_words [$];
    t_out_word expected_events [$];
    int  errors = 0;
    int  sender_idle = 0;
    int  receiver_stall = 0;
    int  wdog = 0;

    function automatic logic [11:0] adiff(logic [11:0] a, logic [11:0] b);
        return a > b ? a - b : b - a;
    endfunction

    task automatic post(logic [KIND_W-1:0] k, int s);
        t_out_word w;
        w.event_kind = k;
        w.slot = s[3:0];
        w.last = 1'b0;
        expected_events.insert(expected_events.size(), w);
    endtask

    task automatic predict_events(t_in_word w);
        int  n0;
        int  wr;
        bit  hit;
        t_track e;
        n0 = expected_events.size();
        hit = 0;
        if (w.opcode == OP_DETECT) begin
            for (int i = 0; i < n_tracks && !hit; i++) begin
                if (adiff(tracks[i].x, w.box_x) < xw && adiff(tracks[i].y, w.box_y) < yw) begin
                    hit = 1;
                    if (tracks[i].det != SAT_MAX) tracks[i].det++;
                    tracks[i].seen = 1;
                    tracks[i].x = w.box_x;
                    tracks[i].y = w.box_y;
                    if (tracks[i].det == dth) begin
                        tracks[i].miss = 0;
                        post(EV_CONFIRMED, i);
                    end
                end
            end
            if (!hit) begin
                if (n_held < NP) begin
                    held[n_held] = {w.box_x, w.box_y};
                    n_held++;
                end else begin
                    post(EV_DROPPED, 0);
                end
            end
        end else begin
            wr = 0;
            for (int i = 0; i < n_tracks; i++) begin
                e = tracks[i];
                if (!e.seen && e.miss != SAT_MAX) e.miss++;
                if (e.miss == mth) begin
                    e.det = 0;
                    e.gone = 1;
                end
                if (9'(e.miss) > 9'(mth) && 9'(e.miss) < 9'(mth) + 9'(ag)) begin
                    e.det = 0;
                    e.gone = 0;
                end
                if (e.gone) post(EV_LEFT, wr);
                if (e.miss != ag) begin
                    e.seen = 0;
                    tracks[wr] = e;
                    wr++;
                end
            end
            n_tracks = wr;
            for (int i = 0; i < n_held; i++) begin
                if (n_tracks < NT) begin
                    tracks[n_tracks] = '{held[i][23:12], held[i][11:0], 8'd1, 8'd0, 0, 0};
                    post(EV_ADDED, n_tracks);
                    n_tracks++;
                end else begin
                    post(EV_DROPPED, 0);
                end
            end
            n_held = 0;
            post(EV_FRAME, 0);
        end
        if (expected_events.size() > n0)
            expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                predict_events(i_in);
                void'(pending_words.pop_front());
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle) begin
                i_push <= 1'b1;
                i_in <= (i_push && !o_full) ? pending_words[0] : pending_words[0];
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (expected_events.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word kind=%0d slot=%0d last=%0d",
                        o_out.event_kind, o_out.slot, o_out.last);
                end else begin
                    want = expected_events.pop_front();
                    if (o_out !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp kind=%0d slot=%0d last=%0d got %0d/%0d/%0d",
                                want.event_kind, want.slot, want.last,
                                o_out.event_kind, o_out.slot, o_out.last);
                    end
                end
            end
            i_pop <= ($urandom_range(99) >= receiver_stall);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_X_WINDOW:    xw = val[11:0];
            REG_Y_WINDOW:    yw = val[11:0];
            REG_DET_THRESH:  dth = val[7:0];
            REG_MISS_THRESH: mth = val[7:0];
            default:         ag = val[7:0];
        endcase
    endtask

    task automatic add_word(bit op, int x, int y);
        t_in_word w;
        w.opcode = op;
        w.box_x = x[11:0];
        w.box_y = y[11:0];
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !i_push);
        wait (expected_events.size() == 0);
        repeat (120) @(posedge i_clk);
    endtask

    // well-formed frames: tracks that move a little, some appearing and vanishing
    task automatic random_frames(int count);
        int ox [6];
        int oy [6];
        int left;
        for (int k = 0; k < 6; k++) begin
            ox[k] = $urandom_range(4095);
            oy[k] = $urandom_range(4095);
        end
        left = count;
        while (left > 0) begin
            for (int k = 0; k < 6 && left > 0; k++) begin
                if ($urandom_range(99) < 70) begin
                    ox[k] = (ox[k] + $urandom_range(6) - 3) & 12'hFFF;
                    oy[k] = (oy[k] + $urandom_range(6) - 3) & 12'hFFF;
                    add_word(OP_DETECT, ox[k], oy[k]);
                    left--;
                end
                if ($urandom_range(99) < 5) begin
                    ox[k] = $urandom_range(4095);
                    oy[k] = $urandom_range(4095);
                end
            end
            if ($urandom_range(99) < 25 && left > 0) begin
                add_word(OP_DETECT, $urandom_range(4095), $urandom_range(4095));
                left--;
            end
            add_word(OP_EOF, $urandom, $urandom);
            left--;
        end
    endtask

    initial begin
        xw = 10; yw = 10; dth = 5; mth = 5; ag = 10;
        n_tracks = 0;
        n_held = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, overflow of pending list and table
        add_word(OP_DETECT, 0, 0);
        add_word(OP_DETECT, 4095, 4095);
        add_word(OP_DETECT, 0, 4095);
        add_word(OP_EOF, 4095, 4095);
        add_word(OP_DETECT, 5, 3);
        add_word(OP_DETECT, 4090, 4092);
        for (int k = 0; k < 17; k++) add_word(OP_DETECT, 200 * k + 100, 3000 - 150 * k);
        add_word(OP_EOF, 0, 0);
        add_word(OP_EOF, 0, 0);
        drain();

        // confirm at threshold one, immediate leave and short afterglow
        cfg_write(REG_X_WINDOW, 4095);
        cfg_write(REG_Y_WINDOW, 1);
        cfg_write(REG_DET_THRESH, 1);
        cfg_write(REG_MISS_THRESH, 1);
        cfg_write(REG_AFTERGLOW, 2);
        random_frames(30);
        drain();

        // a zero x window never matches, and with zero afterglow unseen entries are never removed
        cfg_write(REG_X_WINDOW, 0);
        cfg_write(REG_AFTERGLOW, 0);
        random_frames(15);
        drain();

        sender_idle = 52;
        cfg_write(REG_X_WINDOW, 30);
        cfg_write(REG_Y_WINDOW, 4095);
        cfg_write(REG_DET_THRESH, 3);
        cfg_write(REG_MISS_THRESH, 2);
        cfg_write(REG_AFTERGLOW, 6);
        random_frames(50);
        drain();

        sender_idle = 0;
        receiver_stall = 52;
        cfg_write(REG_X_WINDOW, 10);
        cfg_write(REG_Y_WINDOW, 10);
        cfg_write(REG_DET_THRESH, 255);
        cfg_write(REG_MISS_THRESH, 255);
        cfg_write(REG_AFTERGLOW, 255);
        random_frames(45);
        drain();

        sender_idle = 19;
        receiver_stall = 19;
        cfg_write(REG_DET_THRESH, 2);
        cfg_write(REG_MISS_THRESH, 3);
        cfg_write(REG_AFTERGLOW, 4);
        random_frames(45);
        for (int k = 0; k < 5; k++) add_word(OP_DETECT, $urandom, $urandom);
        add_word(OP_EOF, $urandom, $urandom);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
